// File: sv/hfpp_pkg.sv
// hfpp_pkg: shared constants, codes and the arctan table for the pose predictor
// used by hfpp_div125, hfpp_cordic and heading_fusion_pose_predictor_core
`timescale 1ns / 1ps
package hfpp_pkg;

    // item kinds
    localparam logic [1:0] KIND_UPDATE = 2'd0;
    localparam logic [1:0] KIND_QUERY  = 2'd1;
    localparam logic [1:0] KIND_RESET  = 2'd2;

    // configuration register indexes
    localparam int         CFG_IDX_W      = 2;
    localparam logic [1:0] REG_STALENESS  = 2'd0;
    localparam logic [1:0] REG_HDG_WEIGHT = 2'd1;
    localparam logic [1:0] REG_RATE_WEIGHT = 2'd2;

    // rotation unit sizing
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_ITERS = (CORDIC_STEPS < 30) ? CORDIC_STEPS : 30;
    localparam int CORD_CNT_W   = (CORDIC_ITERS > 1) ? $clog2(CORDIC_ITERS) : 1;
    localparam int VEC_W        = 52;
    localparam int ANG_W        = 36;

    // digit-serial divide by 125
    localparam int DIV_NUM_W  = 68;
    localparam int DIV_DIGITS = DIV_NUM_W / 4;
    localparam int DIV_CNT_W  = $clog2(DIV_DIGITS);

    // fixed-point constants
    localparam logic signed [32:0] K_Q30       = 33'sd652032874;
    localparam logic signed [33:0] PI_Q28      = 34'sd843314857;
    localparam logic signed [33:0] TWO_PI_Q28  = 34'sd1686629713;
    localparam logic signed [33:0] HALF_PI_Q28 = 34'sd421657428;
    localparam logic [6:0]         DIVISOR     = 7'd125;

    // arctan(2^-i) in Q2.30
    function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            5'd0:  v = 36'sd843314856;
            5'd1:  v = 36'sd497837829;
            5'd2:  v = 36'sd263043836;
            5'd3:  v = 36'sd133525158;
            5'd4:  v = 36'sd67021686;
            5'd5:  v = 36'sd33543515;
            5'd6:  v = 36'sd16775850;
            5'd7:  v = 36'sd8388437;
            5'd8:  v = 36'sd4194282;
            5'd9:  v = 36'sd2097149;
            5'd10: v = 36'sd1048575;
            5'd11: v = 36'sd524287;
            5'd12: v = 36'sd262143;
            5'd13: v = 36'sd131071;
            5'd14: v = 36'sd65535;
            5'd15: v = 36'sd32767;
            5'd16: v = 36'sd16383;
            5'd17: v = 36'sd8191;
            5'd18: v = 36'sd4095;
            5'd19: v = 36'sd2047;
            5'd20: v = 36'sd1023;
            5'd21: v = 36'sd511;
            5'd22: v = 36'sd255;
            5'd23: v = 36'sd127;
            5'd24: v = 36'sd63;
            5'd25: v = 36'sd31;
            5'd26: v = 36'sd15;
            5'd27: v = 36'sd8;
            5'd28: v = 36'sd4;
            5'd29: v = 36'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: sv/hfpp_div125.sv
// hfpp_div125: iterative divide by 125, four quotient bits per cycle
// keeps the low 32 quotient bits; depends on hfpp_pkg
`timescale 1ns / 1ps
module hfpp_div125
    import hfpp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_NUM_W-1:0] i_num,
    output logic                 o_busy,
    output logic [31:0]          o_quot
);

    logic [DIV_NUM_W-1:0] r_num, n_num;
    logic [6:0]           r_rem, n_rem;
    logic [31:0]          r_quot, n_quot;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;

    // one radix-16 digit: four restoring steps on a 7-bit remainder
    always_comb begin
        logic [7:0] t;
        n_rem  = r_rem;
        n_quot = r_quot;
        for (int k = 0; k < 4; k++) begin
            t = {n_rem, r_num[DIV_NUM_W-1-k]};
            if (t >= {1'b0, DIVISOR}) begin
                t = t - {1'b0, DIVISOR};
                n_quot = {n_quot[30:0], 1'b1};
            end else begin
                n_quot = {n_quot[30:0], 1'b0};
            end
            n_rem = t[6:0];
        end
        n_num = {r_num[DIV_NUM_W-5:0], 4'b0};
    end

    // sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_DIGITS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= n_num;
            r_rem  <= n_rem;
            r_quot <= n_quot;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

// File: sv/hfpp_cordic.sv
// hfpp_cordic: rotation-mode cordic, one micro-rotation per cycle
// depends on hfpp_pkg for sizes and the arctan table
`timescale 1ns / 1ps
module hfpp_cordic
    import hfpp_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [VEC_W-1:0] i_x,
    input  logic signed [VEC_W-1:0] i_y,
    input  logic signed [ANG_W-1:0] i_z,
    output logic                    o_busy,
    output logic signed [VEC_W-1:0] o_x,
    output logic signed [VEC_W-1:0] o_y
);

    logic signed [VEC_W-1:0] r_x, r_y, w_xs, w_ys;
    logic signed [ANG_W-1:0] r_z, w_atan;
    logic [CORD_CNT_W-1:0]   r_i;
    logic                    r_busy;

    assign w_xs   = r_x >>> r_i;
    assign w_ys   = r_y >>> r_i;
    assign w_atan = atan_q30(5'(r_i));

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_i    <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_i    <= '0;
        end else if (r_busy) begin
            r_i <= r_i + 1'b1;
            if (r_i == CORD_CNT_W'(CORDIC_ITERS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // micro-rotation toward zero angle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_x;
            r_y <= i_y;
            r_z <= i_z;
        end else if (r_busy) begin
            if (r_z >= 0) begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_atan;
            end else begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_atan;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_x    = r_x;
    assign o_y    = r_y;

endmodule

// File: sv/heading_fusion_pose_predictor_core.sv
// heading_fusion_pose_predictor_core: pose store, heading blend and prediction
// an update without a fresh reading is stored at acceptance, one with a blend then
// runs S_BLEND_H, S_BLEND_R and S_BLEND_W; a query with a valid basis runs the setup
// states S_Q_MR to S_Q_Z2, the rotation with the heading divide hidden under it, then
// two position divides in series and the output load; one item at a time
// synchronous active-low reset clears the pose state and loads register defaults
// depends on hfpp_pkg, hfpp_div125, hfpp_cordic
`timescale 1ns / 1ps
module heading_fusion_pose_predictor_core
    import hfpp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    // input items
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_kind,
    input  logic [31:0]          i_time_ms,
    input  logic signed [31:0]   i_pose_x,
    input  logic signed [31:0]   i_pose_y,
    input  logic signed [31:0]   i_pose_heading,
    input  logic signed [31:0]   i_vel_x,
    input  logic signed [31:0]   i_vel_y,
    input  logic signed [31:0]   i_yaw_rate,
    input  logic                 i_fusion_present,
    input  logic [31:0]          i_fusion_time,
    input  logic signed [31:0]   i_fusion_heading,
    input  logic signed [31:0]   i_fusion_rate,
    // result items
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [31:0]   o_est_x,
    output logic signed [31:0]   o_est_y,
    output logic signed [31:0]   o_est_heading,
    output logic signed [31:0]   o_est_vel_x,
    output logic signed [31:0]   o_est_vel_y,
    output logic signed [31:0]   o_est_rate,
    output logic [31:0]          o_est_basis_time,
    output logic                 o_est_valid,
    output logic signed [31:0]   o_resid_heading,
    output logic signed [31:0]   o_resid_rate,
    output logic                 o_resid_valid
);

    // sequencer states
    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_BLEND_H = 5'd1;
    localparam logic [4:0] S_BLEND_R = 5'd2;
    localparam logic [4:0] S_BLEND_W = 5'd3;
    localparam logic [4:0] S_Q_MR    = 5'd4;
    localparam logic [4:0] S_Q_DH    = 5'd5;
    localparam logic [4:0] S_Q_VX    = 5'd6;
    localparam logic [4:0] S_Q_VY    = 5'd7;
    localparam logic [4:0] S_Q_Z2    = 5'd8;
    localparam logic [4:0] S_Q_ROT   = 5'd9;
    localparam logic [4:0] S_Q_MX    = 5'd10;
    localparam logic [4:0] S_Q_DX    = 5'd11;
    localparam logic [4:0] S_Q_DXW   = 5'd12;
    localparam logic [4:0] S_Q_DY    = 5'd13;
    localparam logic [4:0] S_Q_DYW   = 5'd14;
    localparam logic [4:0] S_OUT     = 5'd15;

    logic [4:0]  r_state;
    logic [31:0] r_staleness;
    logic [16:0] r_hdg_w, r_rate_w;

    // stored pose basis
    logic [31:0] r_basis_x, r_basis_y, r_basis_heading, r_basis_vel_x, r_basis_vel_y;
    logic [31:0] r_basis_rate, r_basis_time, r_resid_heading, r_resid_rate;
    logic        r_basis_valid, r_resid_valid;

    // working registers
    logic [31:0]             r_fh, r_fr, r_age, r_ex, r_ey, r_eh;
    logic signed [VEC_W-1:0] r_vx;
    logic signed [33:0]      r_z;
    logic                    r_sx, r_sy;
    logic signed [65:0]      r_prod;

    logic                    w_in_acc, w_fresh, w_mul_en, w_out_load;
    logic [31:0]             w_fage;
    logic signed [32:0]      w_ma, w_mb, w_rate_s, w_rate_abs;
    logic signed [65:0]      w_prod;
    logic [16:0]             w_hdg_w, w_rate_w;
    logic signed [33:0]      w_z0, w_zr, w_zf;
    logic                    w_flip;
    logic signed [VEC_W-1:0] w_cx0, w_cy0, w_cx, w_cy;
    logic signed [35:0]      w_wvx, w_wvy;
    logic [35:0]             w_absx, w_absy;
    logic [31:0]             w_magx, w_magy;
    logic [64:0]             w_pos_sum;
    logic                    w_div_start, w_div_busy, w_cor_start, w_cor_busy;
    logic [DIV_NUM_W-1:0]    w_div_num;
    logic [31:0]             w_quot;

    assign w_in_acc   = i_valid && !o_stall;
    assign o_stall    = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign w_out_load = (r_state == S_OUT) && (!o_valid || !i_stall);

    // fusion freshness
    assign w_fage  = i_time_ms - i_fusion_time;
    assign w_fresh = i_fusion_present && (i_time_ms >= i_fusion_time)
                     && (w_fage <= r_staleness);

    // weights saturate at full replacement
    assign w_hdg_w  = (r_hdg_w > 17'd65536) ? 17'd65536 : r_hdg_w;
    assign w_rate_w = (r_rate_w > 17'd65536) ? 17'd65536 : r_rate_w;

    assign w_rate_s   = {r_basis_rate[31], r_basis_rate};
    assign w_rate_abs = r_basis_rate[31] ? -w_rate_s : w_rate_s;

    // shared multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_BLEND_H: begin
                w_ma = {r_fh[31], r_fh} - {r_basis_heading[31], r_basis_heading};
                w_mb = {16'b0, w_hdg_w};
            end
            S_BLEND_R: begin
                w_ma = {r_fr[31], r_fr} - {r_basis_rate[31], r_basis_rate};
                w_mb = {16'b0, w_rate_w};
            end
            S_Q_MR: begin
                w_ma = w_rate_abs;
                w_mb = {1'b0, r_age};
            end
            S_Q_VX: begin
                w_ma = {r_basis_vel_x[31], r_basis_vel_x};
                w_mb = K_Q30;
            end
            S_Q_VY: begin
                w_ma = {r_basis_vel_y[31], r_basis_vel_y};
                w_mb = K_Q30;
            end
            S_Q_MX: begin
                w_ma = {1'b0, w_magx};
                w_mb = {1'b0, r_age};
            end
            S_Q_DX: begin
                w_ma = {1'b0, w_magy};
                w_mb = {1'b0, r_age};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod   = w_ma * w_mb;
    assign w_mul_en = r_state inside {S_BLEND_H, S_BLEND_R, S_Q_MR, S_Q_VX, S_Q_VY,
                                      S_Q_MX, S_Q_DX};

    // heading wrap into [-pi, pi], then fold into [-pi/2, pi/2]
    assign w_z0 = {r_basis_heading[31], r_basis_heading[31], r_basis_heading};
    always_comb begin
        if (w_z0 > PI_Q28) begin
            w_zr = w_z0 - TWO_PI_Q28;
        end else if (w_z0 < -PI_Q28) begin
            w_zr = w_z0 + TWO_PI_Q28;
        end else begin
            w_zr = w_z0;
        end
        if (r_z > HALF_PI_Q28) begin
            w_zf   = r_z - PI_Q28;
            w_flip = 1'b1;
        end else if (r_z < -HALF_PI_Q28) begin
            w_zf   = r_z + PI_Q28;
            w_flip = 1'b1;
        end else begin
            w_zf   = r_z;
            w_flip = 1'b0;
        end
    end

    assign w_cx0       = w_flip ? -r_vx : r_vx;
    assign w_cy0       = w_flip ? -r_prod[65:14] : r_prod[65:14];
    assign w_cor_start = (r_state == S_Q_Z2);

    hfpp_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cor_start),
        .i_x     (w_cx0),
        .i_y     (w_cy0),
        .i_z     ({w_zf, 2'b00}),
        .o_busy  (w_cor_busy),
        .o_x     (w_cx),
        .o_y     (w_cy)
    );

    // world velocity magnitude, clamped to 32 bits
    assign w_wvx  = w_cx[VEC_W-1:16];
    assign w_wvy  = w_cy[VEC_W-1:16];
    assign w_absx = w_wvx[35] ? 36'(-w_wvx) : 36'(w_wvx);
    assign w_absy = w_wvy[35] ? 36'(-w_wvy) : 36'(w_wvy);
    assign w_magx = (w_absx[35:32] != 4'd0) ? 32'hFFFF_FFFF : w_absx[31:0];
    assign w_magy = (w_absy[35:32] != 4'd0) ? 32'hFFFF_FFFF : w_absy[31:0];

    // divider dividend: rounded heading step or rounded position step
    assign w_pos_sum   = {1'b0, r_prod[63:0]} + 65'd128000;
    assign w_div_start = r_state inside {S_Q_DH, S_Q_DX, S_Q_DY};
    assign w_div_num   = (r_state == S_Q_DH)
                         ? ({3'b0, r_prod[63:0], 1'b0} + DIV_NUM_W'(62))
                         : {14'b0, w_pos_sum[64:11]};

    hfpp_div125 u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_staleness <= 32'd50;
            r_hdg_w     <= '0;
            r_rate_w    <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_STALENESS:   r_staleness <= i_cfg_data;
                REG_HDG_WEIGHT:  r_hdg_w     <= i_cfg_data[16:0];
                REG_RATE_WEIGHT: r_rate_w    <= i_cfg_data[16:0];
                default:         r_staleness <= r_staleness;
            endcase
        end
    end

    // sequencer and pose state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_basis_x       <= '0;
            r_basis_y       <= '0;
            r_basis_heading <= '0;
            r_basis_vel_x   <= '0;
            r_basis_vel_y   <= '0;
            r_basis_rate    <= '0;
            r_basis_time    <= '0;
            r_basis_valid   <= 1'b0;
            r_resid_heading <= '0;
            r_resid_rate    <= '0;
            r_resid_valid   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        case (i_kind)
                            KIND_UPDATE: begin
                                r_basis_x       <= i_pose_x;
                                r_basis_y       <= i_pose_y;
                                r_basis_heading <= i_pose_heading;
                                r_basis_vel_x   <= i_vel_x;
                                r_basis_vel_y   <= i_vel_y;
                                r_basis_rate    <= i_yaw_rate;
                                r_basis_time    <= i_time_ms;
                                r_basis_valid   <= 1'b1;
                                if (w_fresh) begin
                                    r_resid_heading <= i_fusion_heading - i_pose_heading;
                                    r_resid_rate    <= i_fusion_rate - i_yaw_rate;
                                    r_resid_valid   <= 1'b1;
                                    r_state         <= S_BLEND_H;
                                end
                            end
                            KIND_RESET: begin
                                r_basis_x       <= i_pose_x;
                                r_basis_y       <= i_pose_y;
                                r_basis_heading <= i_pose_heading;
                            end
                            KIND_QUERY: begin
                                r_state <= r_basis_valid ? S_Q_MR : S_OUT;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_BLEND_H: r_state <= S_BLEND_R;
                S_BLEND_R: begin
                    r_basis_heading <= r_basis_heading + r_prod[47:16];
                    r_state         <= S_BLEND_W;
                end
                S_BLEND_W: begin
                    r_basis_rate <= r_basis_rate + r_prod[47:16];
                    r_state      <= S_IDLE;
                end
                S_Q_MR:  r_state <= S_Q_DH;
                S_Q_DH:  r_state <= S_Q_VX;
                S_Q_VX:  r_state <= S_Q_VY;
                S_Q_VY:  r_state <= S_Q_Z2;
                S_Q_Z2:  r_state <= S_Q_ROT;
                S_Q_ROT: begin
                    if (!w_cor_busy && !w_div_busy) begin
                        r_state <= S_Q_MX;
                    end
                end
                S_Q_MX:  r_state <= S_Q_DX;
                S_Q_DX:  r_state <= S_Q_DXW;
                S_Q_DXW: begin
                    if (!w_div_busy) begin
                        r_state <= S_Q_DY;
                    end
                end
                S_Q_DY:  r_state <= S_Q_DYW;
                S_Q_DYW: begin
                    if (!w_div_busy) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // working datapath registers
    always_ff @(posedge i_clk) begin
        if (w_mul_en) begin
            r_prod <= w_prod;
        end
        if (w_in_acc) begin
            r_fh  <= i_fusion_heading;
            r_fr  <= i_fusion_rate;
            r_age <= i_time_ms - r_basis_time;
            r_ex  <= r_basis_x;
            r_ey  <= r_basis_y;
            r_eh  <= r_basis_heading;
        end
        if (r_state == S_Q_VY) begin
            r_vx <= r_prod[65:14];
            r_z  <= w_zr;
        end
        if (r_state == S_Q_ROT && !w_cor_busy && !w_div_busy) begin
            r_eh <= r_basis_heading + (r_basis_rate[31] ? -w_quot : w_quot);
        end
        if (r_state == S_Q_MX) begin
            r_sx <= w_wvx[35];
            r_sy <= w_wvy[35];
        end
        if (r_state == S_Q_DXW && !w_div_busy) begin
            r_ex <= r_basis_x + (r_sx ? -w_quot : w_quot);
        end
        if (r_state == S_Q_DYW && !w_div_busy) begin
            r_ey <= r_basis_y + (r_sy ? -w_quot : w_quot);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_out_load) begin
            o_valid <= 1'b1;
        end else if (o_valid && !i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            o_est_x          <= r_ex;
            o_est_y          <= r_ey;
            o_est_heading    <= r_eh;
            o_est_vel_x      <= r_basis_vel_x;
            o_est_vel_y      <= r_basis_vel_y;
            o_est_rate       <= r_basis_rate;
            o_est_basis_time <= r_basis_time;
            o_est_valid      <= r_basis_valid;
            o_resid_heading  <= r_resid_heading;
            o_resid_rate     <= r_resid_rate;
            o_resid_valid    <= r_resid_valid;
        end
    end

    // a new result word is only loaded from the output state
    a_load_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == S_OUT)
        else $error("result loaded outside output state");

    // the divider is never restarted while it is still working
    a_div_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_busy)
        else $error("divider restarted while busy");

    // an accepted update always leaves a valid basis
    a_update_sets_basis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_kind == KIND_UPDATE) |=> r_basis_valid)
        else $error("update did not set basis valid");

    // rotation is finished before position scaling starts
    a_rot_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_Q_MX) |-> !w_cor_busy)
        else $error("position step started during rotation");

endmodule

// File: tb/heading_fusion_pose_predictor_core_test.sv
// heading_fusion_pose_predictor_core_test: self-checking bench for the pose predictor
// drives update, query and reset words with random idling, checks query results
// against a built-in predictor; depends on hfpp_pkg and heading_fusion_pose_predictor_core
`timescale 1ns / 1ps
module heading_fusion_pose_predictor_core_test;
    import hfpp_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] time_ms;
        logic [31:0] px, py, ph, vx, vy, yr;
        logic        fpres;
        logic [31:0] ftime, fhdg, frate;
    } t_pose_word;

    typedef struct packed {
        logic [31:0] x, y, hdg, vx, vy, rate, btime;
        logic        bvalid;
        logic [31:0] rhdg, rrate;
        logic        rvalid;
    } t_pose_est;

    localparam int         WORD_BITS  = $bits(t_pose_word);
    // kind code with no meaning, ignored by the core
    localparam logic [1:0] KIND_SPARE = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic o_cfg_ready, o_stall, o_valid;
    t_pose_word drv = '0;
    logic signed [31:0] o_est_x, o_est_y, o_est_heading, o_est_vel_x, o_est_vel_y, o_est_rate;
    logic signed [31:0] o_resid_heading, o_resid_rate;
    logic [31:0] o_est_basis_time;
    logic o_est_valid, o_resid_valid;

    heading_fusion_pose_predictor_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_kind(drv.kind), .i_time_ms(drv.time_ms),
        .i_pose_x(drv.px), .i_pose_y(drv.py), .i_pose_heading(drv.ph),
        .i_vel_x(drv.vx), .i_vel_y(drv.vy), .i_yaw_rate(drv.yr),
        .i_fusion_present(drv.fpres), .i_fusion_time(drv.ftime),
        .i_fusion_heading(drv.fhdg), .i_fusion_rate(drv.frate),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_est_x(o_est_x), .o_est_y(o_est_y), .o_est_heading(o_est_heading),
        .o_est_vel_x(o_est_vel_x), .o_est_vel_y(o_est_vel_y), .o_est_rate(o_est_rate),
        .o_est_basis_time(o_est_basis_time), .o_est_valid(o_est_valid),
        .o_resid_heading(o_resid_heading), .o_resid_rate(o_resid_rate),
        .o_resid_valid(o_resid_valid)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [31:0] stale_lim, hdg_w, rate_w;
    t_pose_est basis;
    t_pose_est pending_est[$];
    int mismatches = 0;

    // arctan(2^-i) in Q2.30, own copy
    longint atan_tab[30] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
        131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
        127, 63, 31, 15, 8, 4, 2};

    function automatic logic [31:0] mix(logic [31:0] cur, logic [31:0] fus, logic [31:0] w);
        longint c, d, p;
        c = longint'(signed'(cur));
        d = longint'(signed'(fus)) - c;
        if (w > 65536) w = 65536;
        p = d * longint'(w);
        return 32'(c + (p >>> 16));
    endfunction

    function automatic logic [31:0] travel(longint wv, logic [31:0] age);
        logic [63:0] mag, n;
        logic [31:0] d;
        mag = wv < 0 ? 64'(-wv) : 64'(wv);
        if (mag > 64'hFFFF_FFFF) mag = 64'hFFFF_FFFF;
        n = (mag * 64'(age) + 64'd128000) / 64'd256000;
        d = n[31:0];
        return wv < 0 ? -d : d;
    endfunction

    // pose predictor: updates state, returns 1 when a query result is due
    function automatic bit predict_pose(t_pose_word w, output t_pose_est est);
        logic [31:0] h, r, age, dh;
        longint rr, z, ax, ay, xs, ys;
        logic [63:0] m;
        est = basis;
        if (w.kind == KIND_UPDATE) begin
            h = w.ph;
            r = w.yr;
            if (w.fpres && w.time_ms >= w.ftime && (w.time_ms - w.ftime) <= stale_lim) begin
                basis.rhdg = w.fhdg - h;
                basis.rrate = w.frate - r;
                basis.rvalid = 1'b1;
                h = mix(h, w.fhdg, hdg_w);
                r = mix(r, w.frate, rate_w);
            end
            basis.x = w.px; basis.y = w.py; basis.hdg = h;
            basis.vx = w.vx; basis.vy = w.vy; basis.rate = r;
            basis.btime = w.time_ms; basis.bvalid = 1'b1;
            return 0;
        end
        if (w.kind == KIND_RESET) begin
            basis.x = w.px; basis.y = w.py; basis.hdg = w.ph;
            return 0;
        end
        if (w.kind != KIND_QUERY) return 0;
        if (basis.bvalid) begin
            age = w.time_ms - basis.btime;
            rr = longint'(signed'(basis.rate));
            m = 64'(rr < 0 ? -rr : rr) * 64'(age);
            dh = 32'((2 * m + 62) / 125);
            est.hdg = basis.hdg + (rr < 0 ? -dh : dh);
            z = longint'(signed'(basis.hdg));
            ax = (longint'(signed'(basis.vx)) * 652032874) >>> 14;
            ay = (longint'(signed'(basis.vy)) * 652032874) >>> 14;
            while (z > 843314857) z -= 1686629713;
            while (z < -843314857) z += 1686629713;
            if (z > 421657428) begin
                z -= 843314857; ax = -ax; ay = -ay;
            end else if (z < -421657428) begin
                z += 843314857; ax = -ax; ay = -ay;
            end
            z *= 4;
            for (int i = 0; i < CORDIC_ITERS; i++) begin
                xs = ax >>> i;
                ys = ay >>> i;
                if (z >= 0) begin
                    ax -= ys; ay += xs; z -= atan_tab[i];
                end else begin
                    ax += ys; ay -= xs; z += atan_tab[i];
                end
            end
            est.x = basis.x + travel(ax >>> 16, age);
            est.y = basis.y + travel(ay >>> 16, age);
        end
        return 1;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        mismatches++;
    endtask

    // result side: random stall, compare each word with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_est.size() == 0) begin
                report("unexpected word", 0, 0);
            end else begin
                t_pose_est e;
                e = pending_est.pop_front();
                if (o_est_x !== e.x) report("est_x", o_est_x, e.x);
                if (o_est_y !== e.y) report("est_y", o_est_y, e.y);
                if (o_est_heading !== e.hdg) report("est_heading", o_est_heading, e.hdg);
                if (o_est_vel_x !== e.vx) report("est_vel_x", o_est_vel_x, e.vx);
                if (o_est_vel_y !== e.vy) report("est_vel_y", o_est_vel_y, e.vy);
                if (o_est_rate !== e.rate) report("est_rate", o_est_rate, e.rate);
                if (o_est_basis_time !== e.btime)
                    report("est_basis_time", o_est_basis_time, e.btime);
                if (o_est_valid !== e.bvalid) report("est_valid", o_est_valid, e.bvalid);
                if (o_resid_heading !== e.rhdg)
                    report("resid_heading", o_resid_heading, e.rhdg);
                if (o_resid_rate !== e.rrate) report("resid_rate", o_resid_rate, e.rrate);
                if (o_resid_valid !== e.rvalid) report("resid_valid", o_resid_valid, e.rvalid);
            end
        end
    end

    int stall_left = 0;
    bit calm_rx = 0;
    always @(posedge i_clk) begin
        if (!i_stall || stall_left == 0) begin
            if (calm_rx) begin
                i_stall <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_stall <= 1'b1;
            end else begin
                stall_left <= $urandom_range(0, 14);
                i_stall <= 1'b0;
            end
        end else begin
            stall_left <= stall_left - 1;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == REG_STALENESS) stale_lim = val;
        else if (idx == REG_HDG_WEIGHT) hdg_w = val & 32'h1FFFF;
        else if (idx == REG_RATE_WEIGHT) rate_w = val & 32'h1FFFF;
        @(posedge i_clk);
    endtask

    // drain outstanding results, then allow the longest query latency
    task automatic settle();
        i_valid <= 1'b0;
        while (pending_est.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    // send one word after a random gap; optional literal expectation
    task automatic send_word(t_pose_word w, bit quiet, bit has_lit, t_pose_est lit);
        t_pose_est e;
        int gap;
        gap = quiet ? 0 : int'($urandom_range(0, 14));
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        drv <= w;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (predict_pose(w, e)) pending_est.push_back(has_lit ? lit : e);
    endtask

    function automatic t_pose_word rand_word(logic [1:0] kind);
        t_pose_word w;
        w = WORD_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        w.kind = kind;
        return w;
    endfunction

    // mostly plausible motion with random corner values mixed in
    function automatic t_pose_word shaped_word(logic [1:0] kind, logic [31:0] now);
        t_pose_word w;
        w = rand_word(kind);
        if ($urandom_range(0, 9) < 8) begin
            w.time_ms = now;
            w.ph = $urandom_range(0, 1) ? w.ph : 32'($signed($urandom_range(0, 1686629713))
                   - 843314857);
            w.fhdg = w.ph + 32'($signed($urandom_range(0, 4000000)) - 2000000);
            w.ftime = now - $urandom_range(0, 80);
            w.fpres = $urandom_range(0, 3) != 0;
            if ($urandom_range(0, 1)) begin
                w.vx = $signed(w.vx) >>> $urandom_range(0, 20);
                w.vy = $signed(w.vy) >>> $urandom_range(0, 20);
                w.yr = $signed(w.yr) >>> $urandom_range(0, 16);
            end
        end
        return w;
    endfunction

    t_pose_word dir_tab[$];
    t_pose_est zero_est;

    initial begin
        t_pose_word w;
        t_pose_est none;
        logic [31:0] now;
        int wsel;
        stale_lim = 50; hdg_w = 0; rate_w = 0;
        basis = '0;
        none = '0;
        zero_est = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: query before any update returns zero state
        send_word(rand_word(KIND_QUERY), 0, 1, zero_est);
        // reset pose before update: query echoes it unchanged
        w = rand_word(KIND_RESET);
        send_word(w, 0, 0, none);
        send_word(rand_word(KIND_QUERY), 0, 0, none);
        send_word(rand_word(KIND_SPARE), 0, 0, none);
        settle();
        write_reg(REG_HDG_WEIGHT, 32'd65536);
        write_reg(REG_RATE_WEIGHT, 32'h1FFFF);
        write_reg(REG_STALENESS, 32'd0);
        w = '0; w.kind = KIND_UPDATE; w.time_ms = 1000; w.fpres = 1; w.ftime = 1000;
        w.ph = 32'h7FFF_FFFF; w.fhdg = 32'h8000_0000; w.yr = 32'h8000_0000;
        w.frate = 32'h7FFF_FFFF; w.vx = 32'h7FFF_FFFF; w.vy = 32'h8000_0000;
        dir_tab.push_back(w);
        w.kind = KIND_QUERY; w.time_ms = 1000; dir_tab.push_back(w);
        w.time_ms = 999; dir_tab.push_back(w);
        w.time_ms = 32'hFFFF_FFFF; dir_tab.push_back(w);
        w.kind = KIND_UPDATE; w.ftime = 1001; dir_tab.push_back(w);
        w.ftime = 999; w.time_ms = 1000; dir_tab.push_back(w);
        w.fpres = 0; w.ftime = 1000; dir_tab.push_back(w);
        w.kind = KIND_QUERY; w.time_ms = 1500; dir_tab.push_back(w);
        w.kind = KIND_RESET; w.px = 32'h8000_0000; w.py = 32'h7FFF_FFFF;
        w.ph = 32'h8000_0000; dir_tab.push_back(w);
        w.kind = KIND_QUERY; w.time_ms = 1010; dir_tab.push_back(w);
        w.kind = KIND_UPDATE; w.ph = 32'h3243F6A8; w.vx = 32'h0010_0000; w.vy = 0;
        w.yr = 32'hFFF0_0000; w.fpres = 1; w.ftime = 1000; w.time_ms = 1000;
        dir_tab.push_back(w);
        w.kind = KIND_QUERY; w.time_ms = 1250; dir_tab.push_back(w);
        foreach (dir_tab[i]) send_word(dir_tab[i], 0, 0, none);

        // random phases with varied register settings
        now = $urandom;
        for (int ph = 0; ph < 6; ph++) begin
            settle();
            wsel = $urandom_range(0, 2);
            write_reg(REG_STALENESS, ph == 5 ? 32'hFFFF_FFFF : $urandom_range(0, 100));
            write_reg(REG_HDG_WEIGHT, wsel == 0 ? 32'd0 : wsel == 1 ? 32'd65536
                      : $urandom_range(0, 32'h1FFFF));
            write_reg(REG_RATE_WEIGHT, ph == 0 ? 32'd0 : $urandom_range(0, 32'h1FFFF));
            calm_rx = (ph == 2);
            for (int n = 0; n < 240; n++) begin
                int k;
                k = $urandom_range(0, 19);
                now += $urandom_range(0, 60);
                if (k < 8) send_word(shaped_word(KIND_UPDATE, now), ph == 3, 0, none);
                else if (k < 17) send_word(shaped_word(KIND_QUERY, now + $urandom_range(0, 300)),
                                           ph == 3, 0, none);
                else if (k < 19) send_word(rand_word(KIND_RESET), ph == 3, 0, none);
                else send_word(rand_word(2'($urandom_range(0, 3))), ph == 3, 0, none);
            end
        end
        calm_rx = 0;
        settle();
        if (mismatches == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end

    // watchdog
    initial begin
        #40ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
